// ===== rtl/skst_pkg.sv =====
// Shared types and constants for the scancode key state tracker.
`default_nettype none

package skst_pkg;

    localparam int unsigned REG_COUNT  = 8;
    localparam int unsigned CODE_W     = 7;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned BUTTON_W   = 3;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned EVENT_W    = 2;

    localparam logic [BYTE_W-1:0] BYTE_RELEASE = 8'h80;
    localparam logic [BYTE_W-1:0] BYTE_KEYMASK = 8'h7F;
    localparam logic [BYTE_W-1:0] BYTE_EXT     = 8'hE0;
    localparam logic [BYTE_W-1:0] BYTE_DROP1   = 8'hE1;
    localparam logic [BYTE_W-1:0] BYTE_DROP2   = 8'hE2;

    localparam logic KIND_SCAN  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic [CODE_W-1:0] t_code;
    typedef t_code t_code_array [REG_COUNT];

    localparam t_code_array CODE_RESET = '{7'd77, 7'd72, 7'd75, 7'd80,
                                           7'd44, 7'd45, 7'd28, 7'd1};

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE     = 2'd0,
        EV_PRESSED  = 2'd1,
        EV_RELEASED = 2'd2
    } t_event;

    typedef enum logic [2:0] {
        MODE_NONE = 3'b001,
        MODE_EXT  = 3'b010,
        MODE_DROP = 3'b100
    } t_mode;

endpackage

`default_nettype wire

// ===== rtl/scancode_key_state_tracker.sv =====
// Scancode key state tracker: set-1 byte decoder with key tables and button queries.
//
// Usage: one input channel (i_in_valid / o_in_stall) carries beats of either a
// scancode byte (i_kind = 0) or a button query (i_kind = 1). Each query beat
// gives exactly one result beat on the output channel (o_out_valid /
// i_out_stall) holding o_button_event; scancode bytes give no result.
// An input beat is first registered in the input register, then decoded
// against the key tables, and a query's result is written to the output
// register. One beat is taken every cycle while the input channel does not
// stall; the rate is set by the single decode stage, which updates or reads
// the table bits of one key per beat.
// When the receiver stalls with a result waiting, scancode bytes keep flowing
// through the decode stage, while a query waits in the input register and the
// input channel stalls until the output register frees.
// Reset (synchronous, active low) clears both key tables, all read marks and
// any pending prefix, and loads the default button codes. The button code
// registers are written through i_cfg_we / i_cfg_index / i_cfg_data; the user
// must write them only while the block is idle, as the block does not enforce it.
`default_nettype none

module scancode_key_state_tracker #(
    parameter int unsigned NUM_KEYS    = 96,
    parameter int unsigned NUM_BUTTONS = 8,
    parameter int unsigned EXT_BUTTONS = 4
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_kind,
    input  wire logic [skst_pkg::BYTE_W-1:0]       i_scan_byte,
    input  wire logic [skst_pkg::BUTTON_W-1:0]     i_button_id,

    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [skst_pkg::EVENT_W-1:0]           o_button_event,

    input  wire logic                              i_cfg_we,
    input  wire logic [skst_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [skst_pkg::CODE_W-1:0]       i_cfg_data
);

    localparam int unsigned KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    // Input register
    logic                              r_in_valid;
    logic                              r_in_kind;
    logic [skst_pkg::BYTE_W-1:0]       r_in_byte;
    logic [skst_pkg::BUTTON_W-1:0]     r_in_id;

    // Block state
    skst_pkg::t_code_array             r_code;
    skst_pkg::t_mode                   r_mode;
    skst_pkg::t_mode                   n_mode;
    logic [NUM_KEYS-1:0]               r_norm_down;
    logic [NUM_KEYS-1:0]               n_norm_down;
    logic [NUM_KEYS-1:0]               r_ext_down;
    logic [NUM_KEYS-1:0]               n_ext_down;
    logic [NUM_KEYS-1:0]               r_norm_seen;
    logic [NUM_KEYS-1:0]               n_norm_seen;
    logic [NUM_KEYS-1:0]               r_ext_seen;
    logic [NUM_KEYS-1:0]               n_ext_seen;

    // Result register
    logic                              r_out_valid;
    skst_pkg::t_event                  r_event;
    skst_pkg::t_event                  n_event;

    logic                              out_free;
    logic                              advance;
    logic [skst_pkg::CODE_W-1:0]       byte_key;
    logic                              byte_pressed;
    logic                              byte_key_ok;
    logic [skst_pkg::CODE_W-1:0]       query_key;
    logic                              query_key_ok;
    logic                              id_ok;
    logic                              id_ext;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && ((r_in_kind == skst_pkg::KIND_SCAN) || out_free);
    assign o_in_stall = r_in_valid && !advance;

    assign byte_key     = skst_pkg::CODE_W'(r_in_byte & skst_pkg::BYTE_KEYMASK);
    assign byte_pressed = (r_in_byte & skst_pkg::BYTE_RELEASE) == '0;
    assign byte_key_ok  = {1'b0, byte_key} < 8'(NUM_KEYS);

    assign query_key    = r_code[r_in_id];
    assign query_key_ok = {1'b0, query_key} < 8'(NUM_KEYS);
    assign id_ok        = {1'b0, r_in_id} < 4'(NUM_BUTTONS);
    assign id_ext       = {1'b0, r_in_id} < 4'(EXT_BUTTONS);

    always_comb begin
        n_mode      = r_mode;
        n_norm_down = r_norm_down;
        n_ext_down  = r_ext_down;
        n_norm_seen = r_norm_seen;
        n_ext_seen  = r_ext_seen;
        n_event     = skst_pkg::EV_NONE;
        if (advance && (r_in_kind == skst_pkg::KIND_SCAN)) begin
            case (r_mode)
                skst_pkg::MODE_EXT: begin
                    if (byte_key_ok) begin
                        if (r_ext_down[byte_key[KEY_W-1:0]] != byte_pressed) begin
                            n_ext_seen[byte_key[KEY_W-1:0]] = 1'b0;
                        end
                        n_ext_down[byte_key[KEY_W-1:0]] = byte_pressed;
                    end
                    n_mode = skst_pkg::MODE_NONE;
                end
                skst_pkg::MODE_DROP: begin
                    n_mode = skst_pkg::MODE_NONE;
                end
                default: begin
                    if (r_in_byte == skst_pkg::BYTE_EXT) begin
                        n_mode = skst_pkg::MODE_EXT;
                    end else if (r_in_byte == skst_pkg::BYTE_DROP1 ||
                                 r_in_byte == skst_pkg::BYTE_DROP2) begin
                        n_mode = skst_pkg::MODE_DROP;
                    end else if (byte_key_ok) begin
                        if (r_norm_down[byte_key[KEY_W-1:0]] != byte_pressed) begin
                            n_norm_seen[byte_key[KEY_W-1:0]] = 1'b0;
                        end
                        n_norm_down[byte_key[KEY_W-1:0]] = byte_pressed;
                    end
                end
            endcase
        end else if (advance && id_ok && query_key_ok) begin
            if (id_ext) begin
                if (!r_ext_seen[query_key[KEY_W-1:0]]) begin
                    n_event = r_ext_down[query_key[KEY_W-1:0]] ? skst_pkg::EV_PRESSED
                                                               : skst_pkg::EV_RELEASED;
                end
                n_ext_seen[query_key[KEY_W-1:0]] = 1'b1;
            end else begin
                if (!r_norm_seen[query_key[KEY_W-1:0]]) begin
                    n_event = r_norm_down[query_key[KEY_W-1:0]] ? skst_pkg::EV_PRESSED
                                                                : skst_pkg::EV_RELEASED;
                end
                n_norm_seen[query_key[KEY_W-1:0]] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= skst_pkg::MODE_NONE;
            r_norm_down <= '0;
            r_ext_down  <= '0;
            r_norm_seen <= '0;
            r_ext_seen  <= '0;
            r_code      <= skst_pkg::CODE_RESET;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            // A query that decodes this cycle always finds the result register free.
            if (advance && (r_in_kind == skst_pkg::KIND_QUERY)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_mode      <= n_mode;
            r_norm_down <= n_norm_down;
            r_ext_down  <= n_ext_down;
            r_norm_seen <= n_norm_seen;
            r_ext_seen  <= n_ext_seen;
            if (i_cfg_we) begin
                r_code[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_kind <= i_kind;
            r_in_byte <= i_scan_byte;
            r_in_id   <= i_button_id;
        end
        if (advance && (r_in_kind == skst_pkg::KIND_QUERY)) begin
            r_event <= n_event;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_button_event = r_event;

endmodule

`default_nettype wire
